[rtl/core/close_track_merge_keep_leading_core_defines.svh]
// ----------------------------------------------------------------------------
// Close track merge core: assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef CLOSE_TRACK_MERGE_KEEP_LEADING_CORE_DEFINES_SVH
`define CLOSE_TRACK_MERGE_KEEP_LEADING_CORE_DEFINES_SVH

// next-cycle implication, no reset gating
`define CTM_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: lbl failed");

// next-cycle implication, disabled while reset is asserted
`define CTM_ASSERT_NEXT_RST(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: lbl failed");

`endif

[rtl/core/ctm_pkg.sv]
// ----------------------------------------------------------------------------
// Close track merge package
// Track, token and window types plus fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none
package ctm_pkg;

    localparam int ETA_W    = 16;
    localparam int PHI_W    = 16;
    localparam int PT_W     = 20;
    localparam int CHG_W    = 3;
    localparam int IDX_W    = 6;
    localparam int DROP_W   = 6;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 72;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_WIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHI_WIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PT_WIN   = 2'd3;

    typedef struct packed {
        logic signed [ETA_W-1:0] eta;
        logic [PHI_W-1:0]        phi;
        logic [PT_W-1:0]         pt;
        logic signed [CHG_W-1:0] charge;
    } track_t;

    // record of the track under scan, travels one cell per cycle
    typedef struct packed {
        logic   valid;
        logic   alive;
        logic   kill_b;
        track_t trk;
    } token_t;

    typedef struct packed {
        logic [ETA_W-1:0] eta_win;
        logic [PHI_W-1:0] phi_win;
        logic [PT_W-1:0]  pt_win;
    } win_t;

endpackage
`default_nettype wire

[rtl/core/ctm_cell.sv]
// ----------------------------------------------------------------------------
// Close track merge cell
// Holds one track and its dead mark; tests the passing token against it.
// ----------------------------------------------------------------------------
`default_nettype none
module ctm_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            wr_en,
    input  wire ctm_pkg::track_t wr_trk,
    input  wire logic            launch,
    input  wire logic            clear,
    input  wire logic            set_dead,
    input  wire ctm_pkg::win_t   win,
    input  wire ctm_pkg::token_t tok_in,
    output ctm_pkg::token_t      tok_out,
    output ctm_pkg::track_t      trk_out,
    output logic                 dead_out
);

    ctm_pkg::track_t trk_reg;
    ctm_pkg::token_t tok_reg, tok_next;
    logic            dead_reg, dead_next;

    logic signed [ctm_pkg::ETA_W:0] deta;
    logic [ctm_pkg::ETA_W:0]        adeta;
    logic [ctm_pkg::PHI_W-1:0]      dphi;
    logic [ctm_pkg::PHI_W:0]        adphi;
    logic [ctm_pkg::PT_W-1:0]       adpt;
    logic                           hit, lose;

    always_comb begin
        deta  = {tok_in.trk.eta[ctm_pkg::ETA_W-1], tok_in.trk.eta}
              - {trk_reg.eta[ctm_pkg::ETA_W-1], trk_reg.eta};
        adeta = deta[ctm_pkg::ETA_W] ? 17'(-deta) : 17'(deta);
        dphi  = tok_in.trk.phi - trk_reg.phi;
        // wrapped magnitude, half a turn stays 32768
        adphi = (dphi <= 16'h8000) ? {1'b0, dphi} : 17'h10000 - {1'b0, dphi};
        adpt  = (tok_in.trk.pt >= trk_reg.pt) ? tok_in.trk.pt - trk_reg.pt
                                              : trk_reg.pt - tok_in.trk.pt;
        hit   = tok_in.valid && tok_in.alive && !dead_reg
             && (tok_in.trk.charge == trk_reg.charge)
             && (adeta < {1'b0, win.eta_win})
             && (adphi < {1'b0, win.phi_win})
             && (adpt < win.pt_win);
        lose  = hit && (tok_in.trk.pt < trk_reg.pt);

        tok_next = tok_in;
        if (launch) begin
            tok_next.valid  = 1'b1;
            tok_next.alive  = 1'b1;
            tok_next.kill_b = 1'b0;
            tok_next.trk    = trk_reg;
        end else begin
            tok_next.kill_b = hit && !lose;
            tok_next.alive  = tok_in.alive && !lose;
        end

        dead_next = dead_reg;
        if (clear || wr_en) begin
            dead_next = 1'b0;
        end else if (set_dead || (hit && !lose)) begin
            dead_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
            dead_reg      <= 1'b0;
        end else begin
            tok_reg.valid <= tok_next.valid;
            dead_reg      <= dead_next;
        end
        tok_reg.alive  <= tok_next.alive;
        tok_reg.kill_b <= tok_next.kill_b;
        tok_reg.trk    <= tok_next.trk;
        if (wr_en) begin
            trk_reg <= wr_trk;
        end
    end

    assign tok_out  = tok_reg;
    assign trk_out  = trk_reg;
    assign dead_out = dead_reg;

endmodule
`default_nettype wire

[rtl/core/close_track_merge_keep_leading_core.sv]
// Sequence: tracks load while in ST_LOAD; after the last track the pair scan
//   launches a token from each live track a and follows it along the chain,
//   then the last survivor is located and the survivors are emitted.
// A new batch of tracks is not taken until the last one is emitted and then
//   cleared by a clearing pass (ST_CLEAR). Reset is synchronous.
// ----------------------------------------------------------------------------
// Close track merge, keep leading track
// Chain of track cells with a travelling comparison token and a controller
// that loads, scans (when merging is enabled), and emits the survivors in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none
module close_track_merge_keep_leading_core #(
    parameter int MAX_TRACKS = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // config write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [ctm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ctm_pkg::CFG_W-1:0]         cfg_wdata,
    // input tracks
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // s_tdata from bit 0: eta[16], phi[16], pt[20], charge[3], zero pad
    input  wire logic [ctm_pkg::S_DATA_W-1:0]      s_tdata,
    input  wire logic                              s_tlast,   // last_track
    // survivors
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // m_tdata from bit 0: track_index[6], out_eta[16], out_phi[16], out_pt[20],
    //   out_charge[3], dropped_count[6], overflow[1], zero pad
    output logic [ctm_pkg::M_DATA_W-1:0]           m_tdata,
    output logic                                   m_tlast    // last_result
);

    localparam int IW = $clog2(MAX_TRACKS);
    localparam int CW = $clog2(MAX_TRACKS + 1);

    // controller states
    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_SEL   = 3'd1;   // pick next live track a
    localparam logic [2:0] ST_RUN   = 3'd2;   // follow token along chain
    localparam logic [2:0] ST_FIND  = 3'd3;   // locate last survivor
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;

    // configuration registers
    logic                      merge_en_reg;
    ctm_pkg::win_t             win_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            merge_en_reg <= 1'b0;
            win_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ctm_pkg::REG_MERGE_EN: merge_en_reg    <= cfg_wdata[0];
                ctm_pkg::REG_ETA_WIN:  win_reg.eta_win <= cfg_wdata[ctm_pkg::ETA_W-1:0];
                ctm_pkg::REG_PHI_WIN:  win_reg.phi_win <= cfg_wdata[ctm_pkg::PHI_W-1:0];
                ctm_pkg::REG_PT_WIN:   win_reg.pt_win  <= cfg_wdata[ctm_pkg::PT_W-1:0];
                default: ;
            endcase
        end
    end

    // controller registers
    logic [2:0]                state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic                      ovf_reg, ovf_next;
    logic [IW-1:0]             a_reg, a_next;
    logic [IW-1:0]             pos_reg, pos_next;
    logic [IW-1:0]             lp_reg, lp_next;
    logic [CW-1:0]             i_reg, i_next;
    logic [ctm_pkg::DROP_W-1:0] drop_reg, drop_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [ctm_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                      m_tlast_reg, m_tlast_next;

    // chain wiring
    ctm_pkg::token_t           tok_arr [MAX_TRACKS];
    ctm_pkg::track_t           trk_arr [MAX_TRACKS];
    logic [MAX_TRACKS-1:0]     dead_vec;
    logic [MAX_TRACKS-1:0]     wr_vec, launch_vec, set_dead_vec;
    logic                      clear_all;
    ctm_pkg::track_t           in_trk;
    ctm_pkg::token_t           tok_at;
    ctm_pkg::track_t           trk_at;

    assign in_trk.eta    = s_tdata[15:0];
    assign in_trk.phi    = s_tdata[31:16];
    assign in_trk.pt     = s_tdata[51:32];
    assign in_trk.charge = s_tdata[54:52];

    assign tok_at = tok_arr[pos_reg];
    assign trk_at = trk_arr[i_reg[IW-1:0]];

    genvar g;
    generate
        for (g = 0; g < MAX_TRACKS; g++) begin : g_cell
            ctm_pkg::token_t tin;
            if (g == 0) begin : g_head
                assign tin = '0;
            end else begin : g_link
                assign tin = tok_arr[g-1];
            end
            ctm_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .wr_en    (wr_vec[g]),
                .wr_trk   (in_trk),
                .launch   (launch_vec[g]),
                .clear    (clear_all),
                .set_dead (set_dead_vec[g]),
                .win      (win_reg),
                .tok_in   (tin),
                .tok_out  (tok_arr[g]),
                .trk_out  (trk_arr[g]),
                .dead_out (dead_vec[g])
            );
        end
    endgenerate

    assign s_tready = (state_reg == ST_LOAD);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        a_next        = a_reg;
        pos_next      = pos_reg;
        lp_next       = lp_reg;
        i_next        = i_reg;
        drop_next     = drop_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        wr_vec        = '0;
        launch_vec    = '0;
        set_dead_vec  = '0;
        clear_all     = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    if (count_reg == CW'(MAX_TRACKS)) begin
                        ovf_next = 1'b1;
                    end else begin
                        wr_vec[count_reg[IW-1:0]] = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (s_tlast) begin
                        a_next    = '0;
                        drop_next = '0;
                        lp_next   = IW'(count_next - CW'(1));
                        state_next = merge_en_reg ? ST_SEL : ST_FIND;
                    end
                end
            end
            ST_SEL: begin
                if ((CW'(a_reg) + CW'(1)) >= count_reg) begin
                    state_next = ST_FIND;
                end else if (dead_vec[a_reg]) begin
                    a_next = a_reg + IW'(1);
                end else begin
                    launch_vec[a_reg] = 1'b1;
                    pos_next   = a_reg;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // token at pos_reg has been launched from or tested against cell pos_reg
                if (tok_at.kill_b) begin
                    drop_next = drop_reg + ctm_pkg::DROP_W'(1);
                end
                if (!tok_at.alive) begin
                    drop_next = drop_reg + ctm_pkg::DROP_W'(1);
                    set_dead_vec[a_reg] = 1'b1;
                    a_next     = a_reg + IW'(1);
                    state_next = ST_SEL;
                end else if ((CW'(pos_reg) + CW'(1)) == count_reg) begin
                    a_next     = a_reg + IW'(1);
                    state_next = ST_SEL;
                end else begin
                    pos_next = pos_reg + IW'(1);
                end
            end
            ST_FIND: begin
                if (dead_vec[lp_reg]) begin
                    lp_next = lp_reg - IW'(1);
                end else begin
                    i_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_reg == count_reg) begin
                    state_next = ST_CLEAR;
                end else if (dead_vec[i_reg[IW-1:0]]) begin
                    i_next = i_reg + CW'(1);
                end else if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, ovf_reg, drop_reg, trk_at.charge, trk_at.pt,
                                     trk_at.phi, trk_at.eta,
                                     ctm_pkg::IDX_W'(i_reg[IW-1:0])};
                    m_tlast_next  = (i_reg[IW-1:0] == lp_reg);
                    i_next        = i_reg + CW'(1);
                end
            end
            ST_CLEAR: begin
                clear_all  = 1'b1;
                count_next = '0;
                ovf_next   = 1'b0;
                state_next = ST_LOAD;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            a_reg        <= '0;
            pos_reg      <= '0;
            lp_reg       <= '0;
            i_reg        <= '0;
            drop_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            a_reg        <= a_next;
            pos_reg      <= pos_next;
            lp_reg       <= lp_next;
            i_reg        <= i_next;
            drop_reg     <= drop_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

[rtl/core/ctm_checker.sv]
// ----------------------------------------------------------------------------
// Close track merge port checker
// Port-level properties, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "close_track_merge_keep_leading_core_defines.svh"
module ctm_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic                         s_tlast,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [ctm_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                         m_tlast
);

    `CTM_ASSERT_NEXT(a_rst_no_out, aclk, !aresetn, !m_tvalid)
    `CTM_ASSERT_NEXT_RST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `CTM_ASSERT_NEXT_RST(a_close_stops_in, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

bind close_track_merge_keep_leading_core ctm_checker u_ctm_checker (.*);
`default_nettype wire
